>>> sv/mtsm_pkg.sv
// Shared constants, codes, command/status structs and helpers for the mesh tension strain map.
// Used by every interface and module of the block; depends on nothing.
package mtsm_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VERTEX_BITS  = 10;
   localparam int COORD_BITS   = 24;
   localparam int SUM_BITS     = 32;
   localparam int VAL_BITS     = 8;
   localparam int MAG_BITS     = 24;
   localparam int SQ_BITS      = 50;
   localparam int LOG_FRAC     = 24;
   localparam int EXP_BITS     = 6;
   localparam int LOG_BITS     = EXP_BITS + LOG_FRAC;
   localparam int MANT_BITS    = 31;
   localparam int DIV_BITS     = 32;
   localparam int STRAIN_BITS  = 24;
   localparam int COLOR_BITS   = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int NUM_TERMS    = 6;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [15:0] CONTRAST_RESET = 16'd256;
   localparam logic [STRAIN_BITS-1:0] STRAIN_NEG_LIMIT = 24'h800000;
   localparam logic [STRAIN_BITS-1:0] STRAIN_POS_LIMIT = 24'h7FFFFF;
   localparam logic [VAL_BITS-1:0] VAL_MAX = 8'hFF;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_EDGE  = 2'd1,
      REQ_READ  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_COLOR_MODE = 2'd0,
      CSR_CONTRAST   = 2'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      MODE_RGB  = 2'd0,
      MODE_GRB  = 2'd1,
      MODE_BGR  = 2'd2,
      MODE_RAMP = 2'd3
   } color_mode_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_EDGES   = 2'd1,
      STAT_DEGENERATE = 2'd2
   } status_code_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_E_RDA, ST_E_RDB, ST_E_SQI, ST_E_SQ, ST_E_CHK,
      ST_E_LOGP, ST_E_LOGRS, ST_E_LOGR, ST_E_MUL, ST_E_RND,
      ST_U_RDA, ST_U_WRA, ST_U_RDB, ST_U_WRB,
      ST_R_RD, ST_R_DIVS, ST_R_DIV, ST_R_SAT, ST_R_MUL, ST_R_OUT
   } state_type;

   typedef enum logic [1:0] {
      LG_IDLE, LG_NORM, LG_SQ
   } log_phase_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] rest_x;
      logic signed [COORD_BITS-1:0] rest_y;
      logic signed [COORD_BITS-1:0] rest_z;
      logic signed [COORD_BITS-1:0] pose_x;
      logic signed [COORD_BITS-1:0] pose_y;
      logic signed [COORD_BITS-1:0] pose_z;
   } pos_word_type;

   typedef struct packed {
      logic                       deg;
      logic [VAL_BITS-1:0]        val;
      logic signed [SUM_BITS-1:0] sum;
   } acc_word_type;

   typedef struct packed {
      logic capture;
      logic load_we;
      logic pos_rd;
      logic sel_b;
      logic latch_a;
      logic sq_init;
      logic sq_step;
      logic chk;
      logic log_start;
      logic log_rest;
      logic keep_logp;
      logic diff_edge;
      logic mul_edge;
      logic rnd_edge;
      logic acc_rd;
      logic acc_wr;
      logic div_start;
      logic sat_read;
      logic mul_read;
      logic rsp_load;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic sq_done;
      logic zero_len;
      logic log_busy;
      logic log_done;
      logic div_busy;
      logic div_done;
      logic clear_last;
   } sts_type;

   function automatic logic signed [SUM_BITS-1:0] sat_sum(input logic signed [SUM_BITS:0] v);
      logic signed [SUM_BITS-1:0] r;
      if (v[SUM_BITS] != v[SUM_BITS-1]) begin
         r = v[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         r = v[SUM_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic [COLOR_BITS-1:0] clamp16(input logic signed [33:0] v);
      logic [COLOR_BITS-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > 34'sd65535) begin
         r = '1;
      end else begin
         r = v[COLOR_BITS-1:0];
      end
      return r;
   endfunction

endpackage

>>> sv/mtsm_req_if.sv
// Request channel interface: valid/ready plus the request payload.
// Depends on mtsm_pkg.
interface mtsm_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          req_type;
   logic [mtsm_pkg::VERTEX_BITS-1:0]    vertex_index;
   logic [mtsm_pkg::VERTEX_BITS-1:0]    other_vertex;
   logic signed [mtsm_pkg::COORD_BITS-1:0] rest_x;
   logic signed [mtsm_pkg::COORD_BITS-1:0] rest_y;
   logic signed [mtsm_pkg::COORD_BITS-1:0] rest_z;
   logic signed [mtsm_pkg::COORD_BITS-1:0] pose_x;
   logic signed [mtsm_pkg::COORD_BITS-1:0] pose_y;
   logic signed [mtsm_pkg::COORD_BITS-1:0] pose_z;

   modport source (output valid, req_type, vertex_index, other_vertex,
                   rest_x, rest_y, rest_z, pose_x, pose_y, pose_z, input ready);
   modport sink   (input valid, req_type, vertex_index, other_vertex,
                   rest_x, rest_y, rest_z, pose_x, pose_y, pose_z, output ready);
endinterface

>>> sv/mtsm_rsp_if.sv
// Result channel interface: valid/ready plus the read result payload.
// Depends on mtsm_pkg.
interface mtsm_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [mtsm_pkg::VERTEX_BITS-1:0]        read_vertex;
   logic signed [mtsm_pkg::STRAIN_BITS-1:0] strain;
   logic [mtsm_pkg::COLOR_BITS-1:0]         red;
   logic [mtsm_pkg::COLOR_BITS-1:0]         green;
   logic [mtsm_pkg::COLOR_BITS-1:0]         blue;
   logic [mtsm_pkg::COLOR_BITS-1:0]         ramp_position;
   logic [1:0]                              status;

   modport source (output valid, read_vertex, strain, red, green, blue, ramp_position,
                   status, input ready);
   modport sink   (input valid, read_vertex, strain, red, green, blue, ramp_position,
                   status, output ready);
endinterface

>>> sv/mtsm_csr_if.sv
// Configuration write channel interface: valid/ready, register index and data.
// Depends on mtsm_pkg.
interface mtsm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mtsm_pkg::CSR_IDX_BITS-1:0]   index;
   logic [mtsm_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/mtsm_log_unit.sv
// Iterative log2 unit: one-bit-per-cycle normalize, then 24 squaring steps.
// Depends on mtsm_pkg.
module mtsm_log_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mtsm_pkg::SQ_BITS-1:0]     value,
   output logic                             busy,
   output logic                             done,
   output logic [mtsm_pkg::LOG_BITS-1:0]    result
);
   mtsm_pkg::log_phase_type              phase_ff;
   logic [mtsm_pkg::SQ_BITS-1:0]         x_ff;
   logic [mtsm_pkg::EXP_BITS-1:0]        e_ff;
   logic [mtsm_pkg::MANT_BITS-1:0]       m_ff;
   logic [mtsm_pkg::LOG_FRAC-1:0]        frac_ff;
   logic [4:0]                           it_ff;
   logic                                 done_ff;
   logic [2*mtsm_pkg::MANT_BITS-1:0]     sq;
   logic [mtsm_pkg::MANT_BITS:0]         t;

   assign sq = m_ff * m_ff;
   assign t  = sq[2*mtsm_pkg::MANT_BITS-1:mtsm_pkg::MANT_BITS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mtsm_pkg::LG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            mtsm_pkg::LG_IDLE: begin
               if (start) begin
                  phase_ff <= mtsm_pkg::LG_NORM;
               end
            end
            mtsm_pkg::LG_NORM: begin
               if (x_ff[mtsm_pkg::SQ_BITS-1]) begin
                  phase_ff <= mtsm_pkg::LG_SQ;
               end
            end
            mtsm_pkg::LG_SQ: begin
               if (it_ff == 5'(mtsm_pkg::LOG_FRAC - 1)) begin
                  phase_ff <= mtsm_pkg::LG_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: phase_ff <= mtsm_pkg::LG_IDLE;
         endcase
      end
   end

   // datapath of the unit
   always_ff @(posedge clock) begin
      case (phase_ff)
         mtsm_pkg::LG_IDLE: begin
            x_ff <= value;
            e_ff <= mtsm_pkg::EXP_BITS'(mtsm_pkg::SQ_BITS - 1);
         end
         mtsm_pkg::LG_NORM: begin
            if (x_ff[mtsm_pkg::SQ_BITS-1]) begin
               m_ff    <= x_ff[mtsm_pkg::SQ_BITS-1 -: mtsm_pkg::MANT_BITS];
               it_ff   <= '0;
               frac_ff <= '0;
            end else begin
               x_ff <= {x_ff[mtsm_pkg::SQ_BITS-2:0], 1'b0};
               e_ff <= e_ff - 1'b1;
            end
         end
         mtsm_pkg::LG_SQ: begin
            it_ff   <= it_ff + 1'b1;
            frac_ff <= {frac_ff[mtsm_pkg::LOG_FRAC-2:0], t[mtsm_pkg::MANT_BITS]};
            m_ff    <= t[mtsm_pkg::MANT_BITS] ? t[mtsm_pkg::MANT_BITS:1]
                                              : t[mtsm_pkg::MANT_BITS-1:0];
         end
         default: ;
      endcase
   end

   assign busy   = (phase_ff != mtsm_pkg::LG_IDLE);
   assign done   = done_ff;
   assign result = {e_ff, frac_ff};
endmodule

>>> sv/mtsm_div_unit.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 8-bit divisor.
// Depends on mtsm_pkg.
module mtsm_div_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mtsm_pkg::DIV_BITS-1:0]     dividend,
   input  logic [mtsm_pkg::VAL_BITS-1:0]     divisor,
   output logic                              busy,
   output logic                              done,
   output logic [mtsm_pkg::DIV_BITS-1:0]     quotient
);
   logic                                busy_ff;
   logic                                done_ff;
   logic [4:0]                          cnt_ff;
   logic [mtsm_pkg::DIV_BITS-1:0]       quo_ff;
   logic [mtsm_pkg::VAL_BITS-1:0]       den_ff;
   logic [mtsm_pkg::VAL_BITS-1:0]       rem_ff;
   logic [mtsm_pkg::VAL_BITS:0]         shifted;
   logic [mtsm_pkg::VAL_BITS:0]         trial;

   assign shifted = {rem_ff, quo_ff[mtsm_pkg::DIV_BITS-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff && start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'(mtsm_pkg::DIV_BITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // load operands only on start so the quotient holds after done
   always_ff @(posedge clock) begin
      if (!busy_ff) begin
         if (start) begin
            quo_ff <= dividend;
            den_ff <= divisor;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
      end else begin
         cnt_ff <= cnt_ff + 1'b1;
         if (!trial[mtsm_pkg::VAL_BITS]) begin
            rem_ff <= trial[mtsm_pkg::VAL_BITS-1:0];
            quo_ff <= {quo_ff[mtsm_pkg::DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[mtsm_pkg::VAL_BITS-1:0];
            quo_ff <= {quo_ff[mtsm_pkg::DIV_BITS-2:0], 1'b0};
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> sv/mtsm_datapath.sv
// Datapath: position and accumulator memories, squared lengths, strain and colour math,
// configuration registers and the result register. Depends on mtsm_pkg, log and div units.
module mtsm_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mtsm_pkg::cmd_type                     cmd,
   output mtsm_pkg::sts_type                     sts,
   input  logic [mtsm_pkg::VERTEX_BITS-1:0]      req_vertex_index,
   input  logic [mtsm_pkg::VERTEX_BITS-1:0]      req_other_vertex,
   input  mtsm_pkg::pos_word_type                req_pos,
   input  logic                                  csr_we,
   input  logic [mtsm_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [mtsm_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output logic [mtsm_pkg::VERTEX_BITS-1:0]      rsp_read_vertex,
   output logic signed [mtsm_pkg::STRAIN_BITS-1:0] rsp_strain,
   output logic [mtsm_pkg::COLOR_BITS-1:0]       rsp_red,
   output logic [mtsm_pkg::COLOR_BITS-1:0]       rsp_green,
   output logic [mtsm_pkg::COLOR_BITS-1:0]       rsp_blue,
   output logic [mtsm_pkg::COLOR_BITS-1:0]       rsp_ramp_position,
   output logic [1:0]                            rsp_status
);
   // configuration
   mtsm_pkg::color_mode_type                 color_mode_ff;
   logic [mtsm_pkg::CSR_DATA_BITS-1:0]       contrast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= mtsm_pkg::MODE_RGB;
         contrast_ff   <= mtsm_pkg::CONTRAST_RESET;
      end else if (csr_we) begin
         case (mtsm_pkg::csr_reg_type'(csr_index))
            mtsm_pkg::CSR_COLOR_MODE: color_mode_ff <= mtsm_pkg::color_mode_type'(csr_data[1:0]);
            mtsm_pkg::CSR_CONTRAST:   contrast_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // captured endpoints
   logic [mtsm_pkg::VERTEX_BITS-1:0] va_ff, vb_ff, sel_addr;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         va_ff <= req_vertex_index;
         vb_ff <= req_other_vertex;
      end
   end
   assign sel_addr = cmd.sel_b ? vb_ff : va_ff;

   // position memory
   mtsm_pkg::pos_word_type pos_mem [mtsm_pkg::MAX_VERTICES];
   mtsm_pkg::pos_word_type pos_rd_ff, pos_a_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         pos_mem[req_vertex_index] <= req_pos;
      end
      if (cmd.pos_rd) begin
         pos_rd_ff <= pos_mem[sel_addr];
      end
      if (cmd.latch_a) begin
         pos_a_ff <= pos_rd_ff;
      end
   end

   // squared lengths, one coordinate term per cycle
   logic [2:0]                           k_ff;
   logic signed [mtsm_pkg::COORD_BITS-1:0] ca, cb;
   logic signed [mtsm_pkg::COORD_BITS:0] diff;
   logic [mtsm_pkg::MAG_BITS-1:0]        dmag;
   logic [2*mtsm_pkg::MAG_BITS-1:0]      prod_ff;
   logic [mtsm_pkg::SQ_BITS-1:0]         rsum_ff, psum_ff;

   always_comb begin
      case (k_ff)
         3'd0:    begin ca = pos_a_ff.rest_x; cb = pos_rd_ff.rest_x; end
         3'd1:    begin ca = pos_a_ff.rest_y; cb = pos_rd_ff.rest_y; end
         3'd2:    begin ca = pos_a_ff.rest_z; cb = pos_rd_ff.rest_z; end
         3'd3:    begin ca = pos_a_ff.pose_x; cb = pos_rd_ff.pose_x; end
         3'd4:    begin ca = pos_a_ff.pose_y; cb = pos_rd_ff.pose_y; end
         3'd5:    begin ca = pos_a_ff.pose_z; cb = pos_rd_ff.pose_z; end
         default: begin ca = '0; cb = '0; end
      endcase
      diff = {ca[mtsm_pkg::COORD_BITS-1], ca} - {cb[mtsm_pkg::COORD_BITS-1], cb};
      dmag = diff[mtsm_pkg::COORD_BITS] ? mtsm_pkg::MAG_BITS'(-diff)
                                        : diff[mtsm_pkg::MAG_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_init) begin
         k_ff    <= '0;
         rsum_ff <= '0;
         psum_ff <= '0;
      end else if (cmd.sq_step) begin
         k_ff <= k_ff + 1'b1;
         if (k_ff < 3'(mtsm_pkg::NUM_TERMS)) begin
            prod_ff <= dmag * dmag;
         end
         if (k_ff != 3'd0) begin
            if (k_ff <= 3'(mtsm_pkg::NUM_TERMS / 2)) begin
               rsum_ff <= rsum_ff + mtsm_pkg::SQ_BITS'(prod_ff);
            end else begin
               psum_ff <= psum_ff + mtsm_pkg::SQ_BITS'(prod_ff);
            end
         end
      end
   end

   // log2 and edge strain
   logic                            log_busy, log_done;
   logic [mtsm_pkg::LOG_BITS-1:0]   log_result, logp_ff;
   logic signed [mtsm_pkg::LOG_BITS:0] ldiff_ff;
   logic                            eneg_ff;
   logic [mtsm_pkg::LOG_BITS-1:0]   lmag;
   logic [61:0]                     emul_ff;
   logic [63:0]                     eround;
   logic [mtsm_pkg::STRAIN_BITS-1:0] eq;
   logic signed [mtsm_pkg::STRAIN_BITS-1:0] c_ff;
   logic                            degen_ff;

   mtsm_log_unit u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.log_start),
      .value  (cmd.log_rest ? rsum_ff : psum_ff),
      .busy   (log_busy),
      .done   (log_done),
      .result (log_result)
   );

   assign lmag   = ldiff_ff[mtsm_pkg::LOG_BITS] ? mtsm_pkg::LOG_BITS'(-ldiff_ff)
                                                : ldiff_ff[mtsm_pkg::LOG_BITS-1:0];
   assign eround = {2'b0, emul_ff} + (64'd1 << 39);
   assign eq     = eround[40 +: mtsm_pkg::STRAIN_BITS];

   always_ff @(posedge clock) begin
      if (cmd.chk) begin
         degen_ff <= (rsum_ff == '0) || (psum_ff == '0);
      end
      if (cmd.keep_logp) begin
         logp_ff <= log_result;
      end
      if (cmd.diff_edge) begin
         ldiff_ff <= $signed({1'b0, logp_ff}) - $signed({1'b0, log_result});
      end
      if (cmd.mul_edge) begin
         eneg_ff <= ldiff_ff[mtsm_pkg::LOG_BITS];
         emul_ff <= lmag * mtsm_pkg::LN2_Q32;
      end
      if (cmd.rnd_edge) begin
         c_ff <= eneg_ff ? -eq : eq;
      end
   end

   // accumulator memory, cleared by a sweep
   mtsm_pkg::acc_word_type acc_mem [mtsm_pkg::MAX_VERTICES];
   mtsm_pkg::acc_word_type acc_rd_ff, acc_new;
   logic [mtsm_pkg::VERTEX_BITS-1:0] clr_cnt_ff;

   always_comb begin
      acc_new = acc_rd_ff;
      if (degen_ff) begin
         acc_new.deg = 1'b1;
      end else begin
         acc_new.sum = mtsm_pkg::sat_sum({acc_rd_ff.sum[mtsm_pkg::SUM_BITS-1], acc_rd_ff.sum}
                          + (mtsm_pkg::SUM_BITS+1)'(c_ff));
         if (acc_rd_ff.val != mtsm_pkg::VAL_MAX) begin
            acc_new.val = acc_rd_ff.val + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         acc_mem[clr_cnt_ff] <= '0;
      end else if (cmd.acc_wr) begin
         acc_mem[sel_addr] <= acc_new;
      end
      if (cmd.acc_rd) begin
         acc_rd_ff <= acc_mem[sel_addr];
      end
   end

   // read: mean by division, saturate, ramp product
   logic                              div_busy, div_done;
   logic [mtsm_pkg::DIV_BITS-1:0]     quotient, smag_sum;
   logic                              sneg;
   logic [mtsm_pkg::STRAIN_BITS-1:0]  qc;
   logic signed [mtsm_pkg::STRAIN_BITS-1:0] s_ff;
   logic [1:0]                        stat_ff;
   logic [mtsm_pkg::STRAIN_BITS-1:0]  s_mag;
   logic [mtsm_pkg::STRAIN_BITS+mtsm_pkg::COLOR_BITS-1:0] rp_prod_ff;

   assign sneg     = acc_rd_ff.sum[mtsm_pkg::SUM_BITS-1];
   assign smag_sum = sneg ? mtsm_pkg::DIV_BITS'(-acc_rd_ff.sum) : acc_rd_ff.sum;

   mtsm_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (smag_sum + mtsm_pkg::DIV_BITS'(acc_rd_ff.val >> 1)),
      .divisor  (acc_rd_ff.val),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   assign qc    = (quotient > mtsm_pkg::DIV_BITS'(mtsm_pkg::STRAIN_NEG_LIMIT))
                  ? mtsm_pkg::STRAIN_NEG_LIMIT : quotient[mtsm_pkg::STRAIN_BITS-1:0];
   assign s_mag = s_ff[mtsm_pkg::STRAIN_BITS-1] ? mtsm_pkg::STRAIN_BITS'(-s_ff) : s_ff;

   always_ff @(posedge clock) begin
      if (cmd.sat_read) begin
         if (acc_rd_ff.val == '0) begin
            s_ff <= '0;
         end else if (sneg) begin
            s_ff <= -qc;
         end else begin
            s_ff <= (qc == mtsm_pkg::STRAIN_NEG_LIMIT) ? mtsm_pkg::STRAIN_POS_LIMIT : qc;
         end
         if (acc_rd_ff.deg) begin
            stat_ff <= mtsm_pkg::STAT_DEGENERATE;
         end else if (acc_rd_ff.val == '0) begin
            stat_ff <= mtsm_pkg::STAT_NO_EDGES;
         end else begin
            stat_ff <= mtsm_pkg::STAT_OK;
         end
      end
      if (cmd.mul_read) begin
         rp_prod_ff <= s_mag * contrast_ff;
      end
   end

   // colour channels
   logic signed [33:0] s34, one34, oms, omt, tt, rp;
   logic [40:0]        rp_round;
   logic [31:0]        rq;
   logic signed [33:0] rv, gv, bv;
   logic               s_pos;

   always_comb begin
      s34      = 34'(s_ff);
      one34    = 34'sd65536;
      tt       = -s34;
      oms      = one34 - s34;
      omt      = one34 - tt;
      s_pos    = !s_ff[mtsm_pkg::STRAIN_BITS-1] && (s_ff != '0);
      rp_round = {1'b0, rp_prod_ff} + 41'd256;
      rq       = rp_round[40:9];
      rp       = s_ff[mtsm_pkg::STRAIN_BITS-1] ? (34'sd32768 - $signed({2'b0, rq}))
                                              : (34'sd32768 + $signed({2'b0, rq}));
      rv = '0; gv = '0; bv = '0;
      case (color_mode_ff)
         mtsm_pkg::MODE_RGB: begin
            if (s_pos) begin rv = oms; gv = s34; end
            else begin rv = omt; bv = tt; end
         end
         mtsm_pkg::MODE_GRB: begin
            if (s_pos) begin rv = s34; gv = oms; end
            else begin gv = omt; bv = tt; end
         end
         mtsm_pkg::MODE_BGR: begin
            if (s_pos) begin gv = s34; bv = oms; end
            else begin rv = tt; bv = omt; end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_read_vertex   <= va_ff;
         rsp_strain        <= s_ff;
         rsp_red           <= mtsm_pkg::clamp16(rv);
         rsp_green         <= mtsm_pkg::clamp16(gv);
         rsp_blue          <= mtsm_pkg::clamp16(bv);
         rsp_ramp_position <= (color_mode_ff == mtsm_pkg::MODE_RAMP)
                              ? mtsm_pkg::clamp16(rp) : '0;
         rsp_status        <= stat_ff;
      end
   end

   assign sts.sq_done    = (k_ff == 3'(mtsm_pkg::NUM_TERMS));
   assign sts.zero_len   = (rsum_ff == '0) || (psum_ff == '0);
   assign sts.log_busy   = log_busy;
   assign sts.log_done   = log_done;
   assign sts.div_busy   = div_busy;
   assign sts.div_done   = div_done;
   assign sts.clear_last = (clr_cnt_ff == mtsm_pkg::VERTEX_BITS'(mtsm_pkg::MAX_VERTICES - 1));
endmodule

>>> sv/mtsm_ctrl.sv
// Controller state machine: sequences loads, edges, reads and clear sweeps.
// Depends on mtsm_pkg; drives the datapath through cmd_type, watches sts_type.
module mtsm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_type,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  mtsm_pkg::sts_type  sts,
   output mtsm_pkg::cmd_type  cmd
);
   mtsm_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff;
   logic                accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtsm_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtsm_pkg::ST_CLEAR: if (sts.clear_last) state_in = mtsm_pkg::ST_IDLE;
         mtsm_pkg::ST_IDLE: begin
            if (accept) begin
               case (mtsm_pkg::req_code_type'(req_type))
                  mtsm_pkg::REQ_EDGE:  state_in = mtsm_pkg::ST_E_RDA;
                  mtsm_pkg::REQ_READ:  state_in = mtsm_pkg::ST_R_RD;
                  mtsm_pkg::REQ_CLEAR: state_in = mtsm_pkg::ST_CLEAR;
                  default:             state_in = mtsm_pkg::ST_IDLE;
               endcase
            end
         end
         mtsm_pkg::ST_E_RDA:   state_in = mtsm_pkg::ST_E_RDB;
         mtsm_pkg::ST_E_RDB:   state_in = mtsm_pkg::ST_E_SQI;
         mtsm_pkg::ST_E_SQI:   state_in = mtsm_pkg::ST_E_SQ;
         mtsm_pkg::ST_E_SQ:    if (sts.sq_done) state_in = mtsm_pkg::ST_E_CHK;
         mtsm_pkg::ST_E_CHK:   state_in = sts.zero_len ? mtsm_pkg::ST_U_RDA : mtsm_pkg::ST_E_LOGP;
         mtsm_pkg::ST_E_LOGP:  if (sts.log_done) state_in = mtsm_pkg::ST_E_LOGRS;
         mtsm_pkg::ST_E_LOGRS: state_in = mtsm_pkg::ST_E_LOGR;
         mtsm_pkg::ST_E_LOGR:  if (sts.log_done) state_in = mtsm_pkg::ST_E_MUL;
         mtsm_pkg::ST_E_MUL:   state_in = mtsm_pkg::ST_E_RND;
         mtsm_pkg::ST_E_RND:   state_in = mtsm_pkg::ST_U_RDA;
         mtsm_pkg::ST_U_RDA:   state_in = mtsm_pkg::ST_U_WRA;
         mtsm_pkg::ST_U_WRA:   state_in = mtsm_pkg::ST_U_RDB;
         mtsm_pkg::ST_U_RDB:   state_in = mtsm_pkg::ST_U_WRB;
         mtsm_pkg::ST_U_WRB:   state_in = mtsm_pkg::ST_IDLE;
         mtsm_pkg::ST_R_RD:    state_in = mtsm_pkg::ST_R_DIVS;
         mtsm_pkg::ST_R_DIVS:  state_in = mtsm_pkg::ST_R_DIV;
         mtsm_pkg::ST_R_DIV:   if (sts.div_done) state_in = mtsm_pkg::ST_R_SAT;
         mtsm_pkg::ST_R_SAT:   state_in = mtsm_pkg::ST_R_MUL;
         mtsm_pkg::ST_R_MUL:   state_in = mtsm_pkg::ST_R_OUT;
         mtsm_pkg::ST_R_OUT:   if (!rsp_valid_ff || rsp_ready) state_in = mtsm_pkg::ST_IDLE;
         default:              state_in = mtsm_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         mtsm_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         mtsm_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = accept;
            cmd.load_we = accept && (req_type == mtsm_pkg::REQ_LOAD);
         end
         mtsm_pkg::ST_E_RDA:   cmd.pos_rd = 1'b1;
         mtsm_pkg::ST_E_RDB: begin
            cmd.pos_rd  = 1'b1;
            cmd.sel_b   = 1'b1;
            cmd.latch_a = 1'b1;
         end
         mtsm_pkg::ST_E_SQI:   cmd.sq_init = 1'b1;
         mtsm_pkg::ST_E_SQ:    cmd.sq_step = 1'b1;
         mtsm_pkg::ST_E_CHK: begin
            cmd.chk       = 1'b1;
            cmd.log_start = !sts.zero_len;
         end
         mtsm_pkg::ST_E_LOGP:  cmd.keep_logp = sts.log_done;
         mtsm_pkg::ST_E_LOGRS: begin
            cmd.log_start = 1'b1;
            cmd.log_rest  = 1'b1;
         end
         mtsm_pkg::ST_E_LOGR:  cmd.diff_edge = sts.log_done;
         mtsm_pkg::ST_E_MUL:   cmd.mul_edge = 1'b1;
         mtsm_pkg::ST_E_RND:   cmd.rnd_edge = 1'b1;
         mtsm_pkg::ST_U_RDA:   cmd.acc_rd = 1'b1;
         mtsm_pkg::ST_U_WRA:   cmd.acc_wr = 1'b1;
         mtsm_pkg::ST_U_RDB: begin
            cmd.acc_rd = 1'b1;
            cmd.sel_b  = 1'b1;
         end
         mtsm_pkg::ST_U_WRB: begin
            cmd.acc_wr = 1'b1;
            cmd.sel_b  = 1'b1;
         end
         mtsm_pkg::ST_R_RD:    cmd.acc_rd = 1'b1;
         mtsm_pkg::ST_R_DIVS:  cmd.div_start = 1'b1;
         mtsm_pkg::ST_R_SAT:   cmd.sat_read = 1'b1;
         mtsm_pkg::ST_R_MUL:   cmd.mul_read = 1'b1;
         mtsm_pkg::ST_R_OUT:   cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_log_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.log_start |-> !sts.log_busy)
      else $error("log unit started while busy");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == mtsm_pkg::REQ_CLEAR) |=> (state_ff == mtsm_pkg::ST_CLEAR))
      else $error("clear request did not start the sweep");
endmodule

>>> sv/mesh_tension_strain_map.sv
// Top level of the mesh tension strain map: controller plus datapath on three channels.
// Depends on mtsm_pkg, the channel interfaces, mtsm_ctrl and mtsm_datapath.
//
//   channel  | dir | accepted when         | carries
//   ---------+-----+-----------------------+--------------------------------------------
//   req_if   | in  | valid && ready        | req_type, vertex ids, rest and pose coords
//   rsp_if   | out | valid && ready        | read_vertex, strain, colour, ramp, status
//   csr_if   | in  | valid && ready (=1)   | register index, write data
//
// Sequencing: an edge runs two log2 computations on its 50-bit squared lengths, pose
//   then rest, on the shared log unit; a zero-length edge skips them; a read runs the
//   32-step divider; a clear sweeps all 1024 accumulator entries.
// Reset: synchronous; after reset a clearing pass sweeps all 1024 accumulator entries
//   with req_if.ready low. Configuration writes are taken at any time.
// Stalls: a finished read waits in the result register; the block keeps accepting
//   transactions that make no result and stalls only when a second result is ready.
module mesh_tension_strain_map (
   input  logic    clock,
   input  logic    reset,
   mtsm_req_if.sink   req_if,
   mtsm_rsp_if.source rsp_if,
   mtsm_csr_if.sink   csr_if
);
   mtsm_pkg::cmd_type      cmd;
   mtsm_pkg::sts_type      sts;
   mtsm_pkg::pos_word_type req_pos;

   // pack the six coordinates into one memory word
   assign req_pos.rest_x = req_if.rest_x;
   assign req_pos.rest_y = req_if.rest_y;
   assign req_pos.rest_z = req_if.rest_z;
   assign req_pos.pose_x = req_if.pose_x;
   assign req_pos.pose_y = req_if.pose_y;
   assign req_pos.pose_z = req_if.pose_z;

   // configuration writes are always taken
   assign csr_if.ready = 1'b1;

   mtsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mtsm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_vertex_index  (req_if.vertex_index),
      .req_other_vertex  (req_if.other_vertex),
      .req_pos           (req_pos),
      .csr_we            (csr_if.valid),
      .csr_index         (csr_if.index),
      .csr_data          (csr_if.data),
      .rsp_read_vertex   (rsp_if.read_vertex),
      .rsp_strain        (rsp_if.strain),
      .rsp_red           (rsp_if.red),
      .rsp_green         (rsp_if.green),
      .rsp_blue          (rsp_if.blue),
      .rsp_ramp_position (rsp_if.ramp_position),
      .rsp_status        (rsp_if.status)
   );
endmodule

>>> bench/tb_mesh_tension_strain_map.sv
// Self-checking bench for mesh_tension_strain_map: drives vertex loads, edges, reads and clears
// and checks every read against a strain predictor kept in a small scoreboard class.
// Depends on mtsm_pkg, the three channel interfaces and the mesh_tension_strain_map RTL.
`timescale 1ns / 100ps

typedef struct {
   mtsm_pkg::req_code_type                  kind;
   logic [mtsm_pkg::VERTEX_BITS-1:0]        vtx;
   logic [mtsm_pkg::VERTEX_BITS-1:0]        other;
   logic signed [mtsm_pkg::COORD_BITS-1:0]  rest[3];
   logic signed [mtsm_pkg::COORD_BITS-1:0]  pose[3];
} mesh_request;

typedef struct {
   logic [mtsm_pkg::VERTEX_BITS-1:0]        read_vertex;
   logic signed [mtsm_pkg::STRAIN_BITS-1:0] strain;
   logic [mtsm_pkg::COLOR_BITS-1:0]         red;
   logic [mtsm_pkg::COLOR_BITS-1:0]         green;
   logic [mtsm_pkg::COLOR_BITS-1:0]         blue;
   logic [mtsm_pkg::COLOR_BITS-1:0]         ramp_position;
   logic [1:0]                              status;
} strain_reading;

class strain_board;
   logic signed [mtsm_pkg::COORD_BITS-1:0] rest_pos[3][mtsm_pkg::MAX_VERTICES];
   logic signed [mtsm_pkg::COORD_BITS-1:0] pose_pos[3][mtsm_pkg::MAX_VERTICES];
   longint                       sum_q16[mtsm_pkg::MAX_VERTICES];
   int                           edge_count[mtsm_pkg::MAX_VERTICES];
   bit                           degen[mtsm_pkg::MAX_VERTICES];
   mtsm_pkg::color_mode_type     mode;
   logic [15:0]                  contrast;
   strain_reading                readings_due[$];
   int                           fails;

   function new();
      mode = mtsm_pkg::MODE_RGB;
      contrast = mtsm_pkg::CONTRAST_RESET;
      fails = 0;
      wipe_sums();
   endfunction

   function void wipe_sums();
      for (int i = 0; i < mtsm_pkg::MAX_VERTICES; i++) begin
         sum_q16[i] = 0;
         edge_count[i] = 0;
         degen[i] = 0;
      end
   endfunction

   task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      fails++;
   endtask

   function void set_reg(mtsm_pkg::csr_reg_type idx, logic [15:0] val);
      if (idx == mtsm_pkg::CSR_COLOR_MODE)
         mode = mtsm_pkg::color_mode_type'(val[1:0]);
      else if (idx == mtsm_pkg::CSR_CONTRAST)
         contrast = val;
   endfunction

   function longint unsigned span_sq(bit posed, int a, int b);
      longint d;
      longint unsigned acc;
      acc = 0;
      for (int k = 0; k < 3; k++) begin
         if (posed)
            d = longint'(pose_pos[k][a]) - longint'(pose_pos[k][b]);
         else
            d = longint'(rest_pos[k][a]) - longint'(rest_pos[k][b]);
         acc += longint'(d * d);
      end
      return acc;
   endfunction

   // exponent plus 24 fraction bits by repeated squaring of the Q1.30 mantissa
   function longint log2_fixed(longint unsigned x);
      int e;
      longint unsigned m, frac;
      e = 63;
      frac = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
      for (int i = 0; i < mtsm_pkg::LOG_FRAC; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac |= 1;
            m = m >> 1;
         end
      end
      return (longint'(e) << mtsm_pkg::LOG_FRAC) | longint'(frac);
   endfunction

   function longint sat_q16(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function void add_edge(int a, int b);
      longint unsigned lr, lp, mag, q;
      longint d, c;
      lr = span_sq(0, a, b);
      lp = span_sq(1, a, b);
      if (lr == 0 || lp == 0) begin
         degen[a] = 1;
         degen[b] = 1;
         return;
      end
      d = log2_fixed(lp) - log2_fixed(lr);
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q = (mag * 64'(mtsm_pkg::LN2_Q32) + (64'd1 << 39)) >> 40;
      c = (d < 0) ? -longint'(q) : longint'(q);
      sum_q16[a] = sat_q16(sum_q16[a] + c);
      sum_q16[b] = sat_q16(sum_q16[b] + c);
      if (edge_count[a] < 255) edge_count[a]++;
      if (edge_count[b] < 255) edge_count[b]++;
   endfunction

   function logic [mtsm_pkg::COLOR_BITS-1:0] clip16(longint v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return v[mtsm_pkg::COLOR_BITS-1:0];
   endfunction

   function strain_reading predict_read(int v);
      strain_reading res;
      longint s, t, r, g, bl, rp, sum;
      longint unsigned m, q;
      mtsm_pkg::status_code_type st;
      s = 0; r = 0; g = 0; bl = 0; rp = 0;
      st = mtsm_pkg::STAT_NO_EDGES;
      if (edge_count[v] != 0) begin
         sum = sum_q16[v];
         m = (sum < 0) ? longint'(-sum) : longint'(sum);
         q = (m + edge_count[v] / 2) / edge_count[v];
         if (q > 8388608) q = 8388608;
         s = (sum < 0) ? -longint'(q) : longint'(q);
         if (s > 8388607) s = 8388607;
         st = mtsm_pkg::STAT_OK;
      end
      if (degen[v]) st = mtsm_pkg::STAT_DEGENERATE;
      t = -s;
      if (mode == mtsm_pkg::MODE_RAMP) begin
         m = ((s < 0) ? longint'(-s) : longint'(s)) * longint'(contrast);
         q = (m + 256) >> 9;
         rp = 32768 + ((s < 0) ? -longint'(q) : longint'(q));
      end else if (s > 0) begin
         case (mode)
            mtsm_pkg::MODE_RGB: begin r = 65536 - s; g = s; end
            mtsm_pkg::MODE_GRB: begin r = s; g = 65536 - s; end
            default:            begin g = s; bl = 65536 - s; end
         endcase
      end else begin
         case (mode)
            mtsm_pkg::MODE_RGB: begin r = 65536 - t; bl = t; end
            mtsm_pkg::MODE_GRB: begin g = 65536 - t; bl = t; end
            default:            begin r = t; bl = 65536 - t; end
         endcase
      end
      res.read_vertex = v[mtsm_pkg::VERTEX_BITS-1:0];
      res.strain = s[mtsm_pkg::STRAIN_BITS-1:0];
      res.red = clip16(r);
      res.green = clip16(g);
      res.blue = clip16(bl);
      res.ramp_position = (mode == mtsm_pkg::MODE_RAMP) ? clip16(rp) : '0;
      res.status = st;
      return res;
   endfunction

   function void note_request(mesh_request q);
      case (q.kind)
         mtsm_pkg::REQ_LOAD:
            for (int k = 0; k < 3; k++) begin
               rest_pos[k][q.vtx] = q.rest[k];
               pose_pos[k][q.vtx] = q.pose[k];
            end
         mtsm_pkg::REQ_EDGE:  add_edge(q.vtx, q.other);
         mtsm_pkg::REQ_READ:  readings_due.push_back(predict_read(q.vtx));
         default:             wipe_sums();
      endcase
   endfunction

   task check_result(strain_reading got);
      strain_reading want;
      if (readings_due.size() == 0) begin
         report($sformatf("unexpected result for vertex %0d", got.read_vertex));
         return;
      end
      want = readings_due.pop_front();
      if (got.read_vertex !== want.read_vertex)
         report($sformatf("read_vertex %0d, want %0d", got.read_vertex, want.read_vertex));
      if (got.strain !== want.strain)
         report($sformatf("v%0d strain %0d, want %0d", want.read_vertex, got.strain,
                          want.strain));
      if (got.red !== want.red)
         report($sformatf("v%0d red %0d, want %0d", want.read_vertex, got.red, want.red));
      if (got.green !== want.green)
         report($sformatf("v%0d green %0d, want %0d", want.read_vertex, got.green,
                          want.green));
      if (got.blue !== want.blue)
         report($sformatf("v%0d blue %0d, want %0d", want.read_vertex, got.blue, want.blue));
      if (got.ramp_position !== want.ramp_position)
         report($sformatf("v%0d ramp %0d, want %0d", want.read_vertex, got.ramp_position,
                          want.ramp_position));
      if (got.status !== want.status)
         report($sformatf("v%0d status %0d, want %0d", want.read_vertex, got.status,
                          want.status));
   endtask
endclass

module tb_mesh_tension_strain_map;
   localparam logic signed [mtsm_pkg::COORD_BITS-1:0] C_MAX = 24'sh7FFFFF;
   localparam logic signed [mtsm_pkg::COORD_BITS-1:0] C_MIN = 24'sh800000;
   // the slowest non-result transaction is a clear; wait it out before CSR writes
   localparam int QUIET_CYCLES = 1200;

   logic clock;
   logic reset;

   mtsm_req_if req_if ();
   mtsm_rsp_if rsp_if ();
   mtsm_csr_if csr_if ();

   mesh_tension_strain_map dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   strain_board board = new();

   bit sender_calm;      // no sender gaps while set
   bit receiver_calm;    // no receiver stalls while set
   bit hold_results;     // one long receiver hold-off, cleared by the ready process
   bit was_loaded[mtsm_pkg::MAX_VERTICES];
   int loaded_list[$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit: far above the slowest legal run on the 4 ns clock.
   initial begin
      #8ms;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random stalls, a calm stretch, and one long counted hold-off while the
   // sender keeps offering transactions so that the block fills and stalls its input.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_if.ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_results = 0;
         end else begin
            rsp_if.ready <= receiver_calm || ($urandom_range(99) >= 30);
         end
      end
   end

   // Check each accepted result against the oldest expected reading.
   always @(posedge clock) begin
      strain_reading got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.read_vertex   = rsp_if.read_vertex;
         got.strain        = rsp_if.strain;
         got.red           = rsp_if.red;
         got.green         = rsp_if.green;
         got.blue          = rsp_if.blue;
         got.ramp_position = rsp_if.ramp_position;
         got.status        = rsp_if.status;
         board.check_result(got);
      end
   end

   // Offer one transaction, possibly after a random gap, and hold it until accepted.
   task send_request(mesh_request q);
      if (!sender_calm && $urandom_range(99) < 30) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.req_type     <= q.kind;
      req_if.vertex_index <= q.vtx;
      req_if.other_vertex <= q.other;
      req_if.rest_x <= q.rest[0];
      req_if.rest_y <= q.rest[1];
      req_if.rest_z <= q.rest[2];
      req_if.pose_x <= q.pose[0];
      req_if.pose_y <= q.pose[1];
      req_if.pose_z <= q.pose[2];
      do @(posedge clock); while (!req_if.ready);
      board.note_request(q);
   endtask

   task load_vertex(int v, logic signed [mtsm_pkg::COORD_BITS-1:0] rx, ry, rz, px, py, pz);
      mesh_request q;
      q.kind = mtsm_pkg::REQ_LOAD;
      q.vtx = mtsm_pkg::VERTEX_BITS'(v);
      q.other = mtsm_pkg::VERTEX_BITS'($urandom);
      q.rest[0] = rx; q.rest[1] = ry; q.rest[2] = rz;
      q.pose[0] = px; q.pose[1] = py; q.pose[2] = pz;
      send_request(q);
      if (!was_loaded[v]) begin
         was_loaded[v] = 1;
         loaded_list.push_back(v);
      end
   endtask

   // edges, reads and clears carry junk coordinates; the block must ignore them
   task plain_request(mtsm_pkg::req_code_type kind, int a, int b);
      mesh_request q;
      q.kind = kind;
      q.vtx = mtsm_pkg::VERTEX_BITS'(a);
      q.other = mtsm_pkg::VERTEX_BITS'(b);
      for (int k = 0; k < 3; k++) begin
         q.rest[k] = mtsm_pkg::COORD_BITS'($urandom);
         q.pose[k] = mtsm_pkg::COORD_BITS'($urandom);
      end
      send_request(q);
   endtask

   // Drop valid, drain every expected reading, then let the slowest silent transaction finish.
   task settle();
      req_if.valid <= 1'b0;
      while (board.readings_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task write_reg(mtsm_pkg::csr_reg_type idx, logic [15:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      board.set_reg(idx, val);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   function logic signed [mtsm_pkg::COORD_BITS-1:0] pick_coord();
      case ($urandom_range(3))
         0:       return mtsm_pkg::COORD_BITS'($urandom);
         1:       return mtsm_pkg::COORD_BITS'($urandom_range(8191) - 4096);
         2:       return $urandom_range(1) ? C_MAX : C_MIN;
         default: return mtsm_pkg::COORD_BITS'($urandom_range(65535) - 32768);
      endcase
   endfunction

   function int pick_loaded();
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   // Mostly well-formed traffic over a small vertex pool so edges pile up on shared vertices.
   task random_request();
      logic signed [mtsm_pkg::COORD_BITS-1:0] r[3], p[3];
      int v, w, roll;
      roll = $urandom_range(99);
      if (roll < 25 || loaded_list.size() == 0) begin
         v = ($urandom_range(99) < 80) ? $urandom_range(47) : $urandom_range(1023);
         for (int k = 0; k < 3; k++) begin
            r[k] = pick_coord();
            // keep the pose near the rest position half the time for moderate strain
            p[k] = $urandom_range(1) ? pick_coord()
                   : mtsm_pkg::COORD_BITS'(r[k] + $urandom_range(511) - 256);
         end
         load_vertex(v, r[0], r[1], r[2], p[0], p[1], p[2]);
      end else if (roll < 65) begin
         v = pick_loaded();
         w = ($urandom_range(99) < 85) ? pick_loaded() : v;
         plain_request(mtsm_pkg::REQ_EDGE, v, w);
      end else if (roll < 97) begin
         v = ($urandom_range(99) < 70) ? pick_loaded() : $urandom_range(1023);
         plain_request(mtsm_pkg::REQ_READ, v, $urandom_range(1023));
      end else begin
         plain_request(mtsm_pkg::REQ_CLEAR, $urandom_range(1023), $urandom_range(1023));
      end
   endtask

   mtsm_pkg::color_mode_type phase_mode[6] = '{mtsm_pkg::MODE_RAMP, mtsm_pkg::MODE_GRB,
                                               mtsm_pkg::MODE_BGR, mtsm_pkg::MODE_RAMP,
                                               mtsm_pkg::MODE_RAMP, mtsm_pkg::MODE_RGB};
   int             phase_gain[6] = '{65535, 0, -1, 0, -1, 256};

   initial begin
      sender_calm = 0;
      receiver_calm = 0;
      hold_results = 0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.req_type <= mtsm_pkg::REQ_LOAD;
      req_if.vertex_index <= '0;
      req_if.other_vertex <= '0;
      req_if.rest_x <= '0;
      req_if.rest_y <= '0;
      req_if.rest_z <= '0;
      req_if.pose_x <= '0;
      req_if.pose_y <= '0;
      req_if.pose_z <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= mtsm_pkg::CSR_COLOR_MODE;
      csr_if.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings (RGB, unit contrast).
      load_vertex(0, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
      load_vertex(1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
      load_vertex(2, 0, 0, 0, 0, 0, 0);
      load_vertex(3, 0, 0, 0, 4096, 0, 0);            // zero rest length against vertex 2
      load_vertex(4, 4096, 4096, 4096, 4096, 4096, 4096);
      load_vertex(1023, 1, 0, 0, -2048, 8192, 0);
      plain_request(mtsm_pkg::REQ_EDGE, 0, 1);        // widest spans on both poses
      plain_request(mtsm_pkg::REQ_EDGE, 2, 3);        // degenerate rest edge
      plain_request(mtsm_pkg::REQ_EDGE, 0, 0);        // self edge, zero length
      plain_request(mtsm_pkg::REQ_EDGE, 1, 1023);
      plain_request(mtsm_pkg::REQ_EDGE, 4, 2);        // no stretch at all
      plain_request(mtsm_pkg::REQ_EDGE, 1023, 4);
      plain_request(mtsm_pkg::REQ_READ, 0, 1023);
      plain_request(mtsm_pkg::REQ_READ, 1, 0);
      plain_request(mtsm_pkg::REQ_READ, 2, 0);
      plain_request(mtsm_pkg::REQ_READ, 3, 0);
      plain_request(mtsm_pkg::REQ_READ, 4, 0);
      plain_request(mtsm_pkg::REQ_READ, 1023, 0);
      plain_request(mtsm_pkg::REQ_READ, 500, 0);      // vertex with no edges
      plain_request(mtsm_pkg::REQ_CLEAR, 0, 1023);
      plain_request(mtsm_pkg::REQ_READ, 1, 0);        // sums gone after clear
      plain_request(mtsm_pkg::REQ_EDGE, 0, 1023);
      plain_request(mtsm_pkg::REQ_READ, 0, 0);
      plain_request(mtsm_pkg::REQ_READ, 1023, 0);

      // Random phases, each with its color mode and contrast written first.
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         write_reg(mtsm_pkg::CSR_COLOR_MODE, 16'(phase_mode[ph]));
         write_reg(mtsm_pkg::CSR_CONTRAST,
                   (phase_gain[ph] < 0) ? 16'($urandom_range(65535)) : 16'(phase_gain[ph]));
         sender_calm = (ph == 1);
         receiver_calm = (ph == 1);
         if (ph == 3) hold_results = 1;
         for (int i = 0; i < 38; i++) random_request();
      end
      sender_calm = 0;
      receiver_calm = 0;

      // Saturate one pair: huge positive strain drives valence past its limit.
      load_vertex(1000, 0, 0, 0, C_MIN, C_MIN, C_MIN);
      load_vertex(1001, 1, 0, 0, C_MAX, C_MAX, C_MAX);
      for (int i = 0; i < 300; i++) plain_request(mtsm_pkg::REQ_EDGE, 1000, 1001);
      plain_request(mtsm_pkg::REQ_READ, 1000, 0);
      plain_request(mtsm_pkg::REQ_READ, 1001, 0);
      settle();
      write_reg(mtsm_pkg::CSR_COLOR_MODE, 16'(mtsm_pkg::MODE_RAMP));
      write_reg(mtsm_pkg::CSR_CONTRAST, 16'hFFFF);
      plain_request(mtsm_pkg::REQ_READ, 1001, 0);

      settle();
      if (board.readings_due.size() != 0)
         board.report("expected readings never returned");
      if (board.fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

>>> files.f
sv/mtsm_pkg.sv
sv/mtsm_req_if.sv
sv/mtsm_rsp_if.sv
sv/mtsm_csr_if.sv
sv/mtsm_log_unit.sv
sv/mtsm_div_unit.sv
sv/mtsm_datapath.sv
sv/mtsm_ctrl.sv
sv/mesh_tension_strain_map.sv
bench/tb_mesh_tension_strain_map.sv
